// ===== rtl/cssch_pkg.sv =====
// Shared types and constants of the coalescing sweep scheduler.
`default_nettype none
package cssch_pkg;

	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DELAY_W  = 32;
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [DELAY_W-1:0] MIN_GAP_RESET = DELAY_W'(1000);
	localparam logic [DELAY_W-1:0] MAX_GAP_RESET = DELAY_W'(10000);

	typedef enum logic [1:0] {
		ST_DISABLED = 2'd0,
		ST_IDLE     = 2'd1,
		ST_QUEUED   = 2'd2,
		ST_RUNNING  = 2'd3
	} sched_state_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_REQUEST  = 3'd0,
		OP_START    = 3'd1,
		OP_FINISH   = 3'd2,
		OP_SET_DIS  = 3'd3,
		OP_STOP     = 3'd4,
		OP_SHUTDOWN = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_DISABLED   = 3'd1,
		STS_START_REF  = 3'd2,
		STS_BUSY       = 3'd3,
		STS_UNEXP_FIN  = 3'd4
	} status_t;

	typedef enum logic {
		REG_MIN_GAP = 1'b0,
		REG_MAX_GAP = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                disable_value;
		logic [TIME_W-1:0]   now;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                schedule_valid;
		logic [DELAY_W-1:0]  schedule_delay;
		logic [COUNT_W-1:0]  serviced_total;
		logic [COUNT_W-1:0]  event_count;
		logic [1:0]          machine_state;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/cssch_in_if.sv =====
// Event channel into the scheduler.
`default_nettype none
interface cssch_in_if;
	import cssch_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic                disable_value;
	logic [TIME_W-1:0]   now;

	modport source (output valid, opcode, disable_value, now, input ready);
	modport sink   (input valid, opcode, disable_value, now, output ready);
endinterface
`default_nettype wire

// ===== rtl/cssch_out_if.sv =====
// Result channel out of the scheduler.
`default_nettype none
interface cssch_out_if;
	import cssch_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                schedule_valid;
	logic [DELAY_W-1:0]  schedule_delay;
	logic [COUNT_W-1:0]  serviced_total;
	logic [COUNT_W-1:0]  event_count;
	logic [1:0]          machine_state;

	modport source (output valid, status, schedule_valid, schedule_delay, serviced_total,
		event_count, machine_state, input ready);
	modport sink   (input valid, status, schedule_valid, schedule_delay, serviced_total,
		event_count, machine_state, output ready);
endinterface
`default_nettype wire

// ===== rtl/coalescing_sweep_scheduler.sv =====
// Coalescing sweep scheduler: takes one event per clock while results are taken, returns
// one result per event. An event passes an input register, then the result register that
// offers it. The scheduler state, tallies and last sweep time update in the same cycle
// the event leaves the input register, so the next event already sees them. Back-pressure
// on the result side stalls the input only once both registers are full. The user must
// write the minimum delay (0x0) and target sweep spacing (0x4) over the APB port only
// while no event is in flight; the block does not enforce it.
`default_nettype none
module coalescing_sweep_scheduler (
	input  wire                         clk,
	input  wire                         arst_n,
	cssch_in_if.sink                    req,
	cssch_out_if.source                 rsp,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [cssch_pkg::PADDR_W-1:0] paddr,
	input  wire [cssch_pkg::PDATA_W-1:0] pwdata,
	output logic [cssch_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import cssch_pkg::*;

	logic [DELAY_W-1:0] min_gap_q, max_gap_q;
	logic               cfg_wr;
	reg_index_t         cfg_idx;

	in_item_t     item_s1;
	logic         valid_s1;
	out_item_t    res_s2;
	logic         valid_s2;
	logic         advance;

	sched_state_t state_q, state_d;
	logic         dis_q, dis_d;
	logic         shut_q, shut_d;
	logic [COUNT_W-1:0] pend_q, pend_d;
	logic [COUNT_W-1:0] serv_q, serv_d;
	logic [TIME_W-1:0]  last_q, last_d;
	out_item_t    res_d;

	logic [TIME_W-1:0]  next_t, diff_t;
	logic               after_t;
	logic [DELAY_W-1:0] sched_dly;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_idx = reg_index_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (cfg_idx == REG_MAX_GAP) ? max_gap_q : min_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RESET;
			max_gap_q <= MAX_GAP_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MIN_GAP: min_gap_q <= pwdata;
				REG_MAX_GAP: max_gap_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Handshake
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.opcode        <= req.opcode;
			item_s1.disable_value <= req.disable_value;
			item_s1.now           <= req.now;
		end
		if (advance && valid_s1)
			res_s2 <= res_d;
	end

	// Delay for a newly queued sweep; signed-wrap test of next against now
	always_comb begin
		next_t  = last_q + TIME_W'(max_gap_q);
		diff_t  = next_t - item_s1.now;
		after_t = (diff_t != '0) && !diff_t[TIME_W-1];
		if (after_t && !shut_q)
			sched_dly = (DELAY_W'(diff_t) < min_gap_q) ? min_gap_q : DELAY_W'(diff_t);
		else
			sched_dly = min_gap_q;
	end

	// Event decode
	always_comb begin
		state_d = state_q;
		dis_d   = dis_q;
		shut_d  = shut_q;
		pend_d  = pend_q;
		serv_d  = serv_q;
		last_d  = last_q;
		res_d   = '0;
		res_d.status = STS_OK;

		case (opcode_t'(item_s1.opcode))
			OP_REQUEST: begin
				pend_d = pend_q + COUNT_W'(1);
				if (state_q == ST_DISABLED) begin
					res_d.status = STS_DISABLED;
				end else if (state_q == ST_IDLE && pend_q == serv_q) begin
					state_d              = ST_QUEUED;
					res_d.schedule_valid = 1'b1;
					res_d.schedule_delay = sched_dly;
				end
			end
			OP_START: begin
				if (state_q == ST_QUEUED) begin
					state_d              = ST_RUNNING;
					serv_d               = pend_q;
					last_d               = item_s1.now;
					res_d.event_count    = pend_q - serv_q;
					res_d.serviced_total = pend_q;
				end else begin
					res_d.status = STS_START_REF;
				end
			end
			OP_FINISH: begin
				if (state_q == ST_RUNNING) begin
					if (dis_q) begin
						state_d = ST_DISABLED;
					end else if (pend_q == serv_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d              = ST_QUEUED;
						res_d.schedule_valid = 1'b1;
						res_d.schedule_delay = sched_dly;
					end
				end else begin
					res_d.status = STS_UNEXP_FIN;
				end
			end
			OP_SET_DIS: begin
				case (state_q)
					ST_DISABLED: begin
						dis_d = item_s1.disable_value;
						if (!item_s1.disable_value) begin
							state_d = ST_IDLE;
							if (pend_q != serv_q) begin
								state_d              = ST_QUEUED;
								res_d.schedule_valid = 1'b1;
								res_d.schedule_delay = sched_dly;
							end
						end
					end
					ST_IDLE: begin
						dis_d = item_s1.disable_value;
						if (item_s1.disable_value)
							state_d = ST_DISABLED;
					end
					default: res_d.status = STS_BUSY;
				endcase
			end
			OP_STOP: begin
				dis_d = 1'b1;
				if (state_q == ST_IDLE)
					state_d = ST_DISABLED;
			end
			OP_SHUTDOWN: shut_d = 1'b1;
			default: ;
		endcase
		res_d.machine_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dis_q   <= 1'b0;
			shut_q  <= 1'b0;
			pend_q  <= '0;
			serv_q  <= '0;
			last_q  <= '0;
		end else if (advance && valid_s1) begin
			state_q <= state_d;
			dis_q   <= dis_d;
			shut_q  <= shut_d;
			pend_q  <= pend_d;
			serv_q  <= serv_d;
			last_q  <= last_d;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.status         = res_s2.status;
	assign rsp.schedule_valid = res_s2.schedule_valid;
	assign rsp.schedule_delay = res_s2.schedule_delay;
	assign rsp.serviced_total = res_s2.serviced_total;
	assign rsp.event_count    = res_s2.event_count;
	assign rsp.machine_state  = res_s2.machine_state;

	// A scheduled sweep always leaves the machine queued
	a_sched_queued: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.schedule_valid |-> res_s2.machine_state == ST_QUEUED)
		else $error("scheduled sweep without queued state");

	// Delay never falls below the configured minimum
	a_delay_min: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.schedule_valid |-> res_s2.schedule_delay >= min_gap_q)
		else $error("schedule delay below the configured minimum");

	// Busy refusal only happens with a sweep queued or running
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == STS_BUSY |->
		res_s2.machine_state == ST_QUEUED || res_s2.machine_state == ST_RUNNING)
		else $error("busy status outside queued or running");

	// A successful start drains the pending tally
	a_start_drain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && item_s1.opcode == OP_START && state_q == ST_QUEUED
		|=> serv_q == $past(pend_q))
		else $error("sweep start did not take all pending requests");

	// An empty result register never blocks the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> req.ready)
		else $error("input stalled with empty result register");

endmodule
`default_nettype wire
